FILE: sv/ppr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppr_pkg;

  // Fixed field and register widths
  localparam int SPAN_W      = 15;
  localparam int GAIN_W      = 16;
  localparam int BAND_W      = 15;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int POS_IN_W    = 16;
  localparam int JOY_W       = 8;
  localparam int MAG_W       = 15;
  localparam int FRAC_BITS   = 16;

  // Default state widths
  localparam int POSITION_WIDTH_DEF = 16;
  localparam int INTEGRAL_WIDTH_DEF = 32;

  // Register reset values
  localparam logic [SPAN_W-1:0] SPAN_RST = 15'd0;
  localparam logic [GAIN_W-1:0] KP_RST   = 16'd22938;
  localparam logic [GAIN_W-1:0] KI_RST   = 16'd573;
  localparam logic [BAND_W-1:0] BAND_RST = 15'd500;

  // Joystick mapping
  localparam int JOY_OFFSET = 38;
  localparam int JOY_CENTER = 115;
  localparam int JOY_SCALE  = 100;

  localparam logic [MAG_W-1:0] MAG_MAX = 15'h7FFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SPAN = 2'd0,
    REG_KP   = 2'd1,
    REG_KI   = 2'd2,
    REG_BAND = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: sv/position_pi_regulator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Position PI regulator. One word is accepted every cycle while in_ready
// is high; a control tick gives its drive word through the B, C and output
// registers, a reference update gives none. The rate is set by the target
// and integral update in the first stage, followed by a multiply stage and
// a sum/truncate/saturate stage into the output register. Configuration
// registers are written through cfg_we/cfg_index/cfg_data and take effect
// at once; write them only while no word is in flight. No start-up sweep.
module position_pi_regulator_top #(
  parameter int POSITION_WIDTH = ppr_pkg::POSITION_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = ppr_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ppr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ppr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               action,
  input  logic signed [ppr_pkg::POS_IN_W-1:0] encoder_position,
  input  logic [ppr_pkg::JOY_W-1:0]          joystick_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               drive_negative,
  output logic [ppr_pkg::MAG_W-1:0]          drive_magnitude
);
  import ppr_pkg::*;

  localparam int P   = POSITION_WIDTH;
  localparam int I   = INTEGRAL_WIDTH;
  localparam int RW  = 18;
  localparam int SW  = (P > RW) ? P : RW;
  localparam int CW  = ((P > POS_IN_W) ? P : POS_IN_W) + 1;
  localparam int DW  = I + 18;
  localparam int QW  = DW - FRAC_BITS;
  localparam int SQ  = (P > QW) ? P : QW;
  localparam int MW  = P + 1;
  localparam longint PMAX = (longint'(1) << (P - 1)) - 1;
  localparam longint PMIN = -PMAX - 1;

  // Configuration
  logic [SPAN_W-1:0] span;
  logic [GAIN_W-1:0] kp;
  logic [GAIN_W-1:0] ki;
  logic [BAND_W-1:0] band;

  always_ff @(posedge clk) begin
    if (rst) begin
      span <= SPAN_RST;
      kp   <= KP_RST;
      ki   <= KI_RST;
      band <= BAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SPAN: span <= cfg_data[SPAN_W-1:0];
        REG_KP:   kp   <= cfg_data[GAIN_W-1:0];
        REG_KI:   ki   <= cfg_data[GAIN_W-1:0];
        REG_BAND: band <= cfg_data[BAND_W-1:0];
      endcase
    end
  end

  // Pipeline control
  logic a_valid, b_valid, c_valid;
  logic o_ready, c_ready, b_ready, a_fire;

  logic                       a_action;
  logic signed [POS_IN_W-1:0] a_pos;
  logic [JOY_W-1:0]           a_joy;

  assign o_ready  = !out_valid || out_ready;
  assign c_ready  = !c_valid || o_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_fire   = a_valid && (a_action || b_ready);
  assign in_ready = !a_valid || a_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_action <= action;
      a_pos    <= encoder_position;
      a_joy    <= joystick_value;
    end
  end

  // Stage A: reference mapping, clamping, error and integral
  logic signed [P-1:0] target;
  logic                target_set;
  logic signed [I-1:0] integral;

  logic [SPAN_W-1:0]          half;
  logic [JOY_W-1:0]           joy_r;
  logic signed [JOY_W:0]      joy_d;
  logic signed [15:0]         joy_p;
  logic signed [RW-1:0]       ref_val;
  logic signed [SW-1:0]       ref_ext;
  logic signed [P-1:0]        ref_sat;
  logic [SPAN_W-1:0]          pos_c;
  logic signed [CW-1:0]       tgt_ext;
  logic [SPAN_W-1:0]          tgt_c;
  logic signed [POS_IN_W-1:0] err;
  logic [SPAN_W-1:0]          aerr;
  logic signed [I:0]          isum;
  logic signed [I-1:0]        integ_next;

  always_comb begin
    half    = span >> 1;
    joy_r   = (a_joy < JOY_W'(2 * JOY_OFFSET)) ? JOY_W'(JOY_OFFSET)
                                               : a_joy - JOY_W'(JOY_OFFSET);
    joy_d   = $signed({1'b0, joy_r}) - $signed((JOY_W + 1)'(JOY_CENTER));
    joy_p   = 16'(joy_d) * $signed(16'(JOY_SCALE));
    ref_val = $signed(RW'(half)) - RW'(joy_p);
    ref_ext = SW'(ref_val);
    if (ref_ext > SW'(PMAX)) begin
      ref_sat = P'(PMAX);
    end else if (ref_ext < SW'(PMIN)) begin
      ref_sat = P'(PMIN);
    end else begin
      ref_sat = P'(ref_ext);
    end

    if (a_pos[POS_IN_W-1]) begin
      pos_c = '0;
    end else if (a_pos[SPAN_W-1:0] > span) begin
      pos_c = span;
    end else begin
      pos_c = a_pos[SPAN_W-1:0];
    end

    tgt_ext = CW'(target);
    if (!target_set) begin
      tgt_c = half;
    end else if (tgt_ext < 0) begin
      tgt_c = '0;
    end else if (tgt_ext > $signed(CW'(span))) begin
      tgt_c = span;
    end else begin
      tgt_c = SPAN_W'(tgt_ext);
    end

    err  = $signed({1'b0, tgt_c}) - $signed({1'b0, pos_c});
    aerr = err[POS_IN_W-1] ? SPAN_W'(-err) : err[SPAN_W-1:0];
    isum = (I + 1)'(integral) + (I + 1)'(err);
    if (aerr < band) begin
      integ_next = '0;
    end else if (isum[I] != isum[I-1]) begin
      integ_next = {isum[I], {(I - 1){~isum[I]}}};
    end else begin
      integ_next = isum[I-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target     <= '0;
      target_set <= 1'b0;
      integral   <= '0;
    end else if (a_fire) begin
      if (a_action) begin
        target     <= ref_sat;
        target_set <= 1'b1;
      end else begin
        integral <= integ_next;
        if (target_set) begin
          target <= P'(tgt_c);
        end
      end
    end
  end

  // Stage B: products
  logic signed [POS_IN_W-1:0] b_err;
  logic signed [I-1:0]        b_integ;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid && !a_action;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid && !a_action) begin
      b_err   <= err;
      b_integ <= integ_next;
    end
  end

  logic signed [32:0]   c_pprod;
  logic signed [I+16:0] c_iprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) begin
      c_pprod <= 33'($signed({1'b0, kp})) * 33'(b_err);
      c_iprod <= (I + 17)'($signed({1'b0, ki})) * (I + 17)'(b_integ);
    end
  end

  // Stage C: sum, truncate toward zero, saturate, split into sign and size
  logic signed [DW-1:0] dsum;
  logic [DW-1:0]        bias;
  logic signed [DW-1:0] dadj;
  logic signed [QW-1:0] q;
  logic signed [SQ-1:0] q_ext;
  logic signed [P-1:0]  d;
  logic signed [MW-1:0] dw;
  logic [MW-1:0]        mag_full;
  logic [MAG_W-1:0]     mag;

  always_comb begin
    dsum  = DW'(c_pprod) + DW'(c_iprod);
    bias  = dsum[DW-1] ? DW'((1 << FRAC_BITS) - 1) : '0;
    dadj  = dsum + $signed(bias);
    q     = $signed(dadj[DW-1:FRAC_BITS]);
    q_ext = SQ'(q);
    if (q_ext > SQ'(PMAX)) begin
      d = P'(PMAX);
    end else if (q_ext < SQ'(PMIN)) begin
      d = P'(PMIN);
    end else begin
      d = P'(q_ext);
    end
    dw       = MW'(d);
    mag_full = d[P-1] ? $unsigned(-dw) : $unsigned(dw);
    if ((MW + 16)'(mag_full) > (MW + 16)'(MAG_MAX)) begin
      mag = MAG_MAX;
    end else begin
      mag = MAG_W'(mag_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_ready) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && c_valid) begin
      drive_negative  <= d[P-1];
      drive_magnitude <= mag;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ppr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ppr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        drive_negative,
  input logic [ppr_pkg::MAG_W-1:0]   drive_magnitude
);
  import ppr_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_negative)
      && $stable(drive_magnitude))
    else $error("stalled result word changed or dropped");

  // Zero drive carries no direction
  a_no_neg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_negative |-> drive_magnitude != '0)
    else $error("negative direction with zero magnitude");

  // An empty output side never stalls the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with output register empty");

  // Reset drops every word in flight
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind position_pi_regulator_top ppr_checker u_ppr_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .drive_negative  (drive_negative),
  .drive_magnitude (drive_magnitude)
);

`default_nettype wire
